// ===== hdl/luhn_pkg.sv =====
// Shared widths, result types and digit helpers for the card number Luhn classifier.
package luhn_pkg;

	// Width of the binary card number.
	localparam int IN_W = 63;
	// Decimal digits needed to hold any value of IN_W bits.
	localparam int NUM_BCD = 19;
	localparam int BCD_W = NUM_BCD * 4;
	// Longest number that is still checked; longer ones are reported as overflow.
	localparam int MAX_DIGITS = 19;

	// Counter and index widths.
	localparam int CNT_W = $clog2(NUM_BCD + 1);
	localparam int IDX_W = $clog2(NUM_BCD);
	localparam int BIT_CNT_W = $clog2(IN_W);

	// Stream widths, padded to whole bytes.
	localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int M_TDATA_W = 8;

	// Card kinds.
	localparam logic [1:0] KIND_INVALID = 2'd0;
	localparam logic [1:0] KIND_LEN15_34_37 = 2'd1;
	localparam logic [1:0] KIND_PREFIX_4 = 2'd2;
	localparam logic [1:0] KIND_PREFIX_51_55 = 2'd3;

	// Result of one item.
	typedef struct packed {
		logic [CNT_W-1:0] digit_count;
		logic             checksum_ok;
		logic [1:0]       card_kind;
	} luhn_res_t;

	// Digit sum of twice a decimal digit.
	function automatic logic [3:0] dbl_digit_sum(input logic [3:0] d);
		logic [4:0] r;
		begin
			r = {d, 1'b0};
			if (d >= 4'd5) begin
				r = r - 5'd9;
			end
			return r[3:0];
		end
	endfunction

endpackage

// ===== hdl/luhn_bcd_conv.sv =====
// Bit-serial binary to BCD converter using the shift-and-add-three method.
module luhn_bcd_conv
	import luhn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IN_W-1:0]  bin,
	output logic             done,
	output logic [BCD_W-1:0] bcd
);

	logic [IN_W-1:0]      bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [BCD_W-1:0]     adj;

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < NUM_BCD; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// One binary bit enters the BCD register each cycle, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BIT_CNT_W'(IN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Payload shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[IN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[IN_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== hdl/luhn_digit_scan.sv =====
// Digit-serial Luhn sum, length count and prefix classification over the BCD digits.
module luhn_digit_scan
	import luhn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [BCD_W-1:0] bcd,
	output logic             done,
	output luhn_res_t        res
);

	logic [BCD_W-1:0] sh_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       first_q;
	logic [3:0]       second_q;
	logic [3:0]       prev_q;
	logic             busy_q;
	logic             done_q;

	logic [3:0] d;
	logic [3:0] contrib;
	logic [4:0] sum_w;
	logic [3:0] sum_next;

	// Contribution of the current digit, with every second digit doubled.
	always_comb begin
		d        = sh_q[3:0];
		contrib  = idx_q[0] ? dbl_digit_sum(d) : d;
		sum_w    = {1'b0, sum_q} + {1'b0, contrib};
		sum_next = (sum_w >= 5'd10) ? 4'(sum_w - 5'd10) : sum_w[3:0];
	end

	// Control of the digit pass, least significant digit first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (idx_q == IDX_W'(NUM_BCD - 1));
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IDX_W'(NUM_BCD - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Running sum modulo ten, and the highest non-zero digit with its lower neighbour.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q     <= bcd;
			sum_q    <= '0;
			cnt_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			prev_q   <= '0;
		end else if (busy_q) begin
			sh_q   <= {4'd0, sh_q[BCD_W-1:4]};
			sum_q  <= sum_next;
			prev_q <= d;
			if (d != 4'd0) begin
				cnt_q    <= CNT_W'(idx_q) + 1'b1;
				first_q  <= d;
				second_q <= prev_q;
			end
		end
	end

	// Final classification from the gathered digits.
	always_comb begin
		res.digit_count = cnt_q;
		res.checksum_ok = (sum_q == 4'd0);
		res.card_kind   = KIND_INVALID;
		if (cnt_q > CNT_W'(MAX_DIGITS)) begin
			res.digit_count = CNT_W'(MAX_DIGITS);
			res.checksum_ok = 1'b0;
		end else if (sum_q == 4'd0) begin
			if (cnt_q == CNT_W'(15) && first_q == 4'd3 &&
				(second_q == 4'd4 || second_q == 4'd7)) begin
				res.card_kind = KIND_LEN15_34_37;
			end else if ((cnt_q == CNT_W'(13) || cnt_q == CNT_W'(16)) && first_q == 4'd4) begin
				res.card_kind = KIND_PREFIX_4;
			end else if (cnt_q == CNT_W'(16) && first_q == 4'd5 &&
				second_q >= 4'd1 && second_q <= 4'd5) begin
				res.card_kind = KIND_PREFIX_51_55;
			end
		end
	end

	assign done = done_q;

endmodule

// ===== hdl/card_number_luhn_classifier.sv =====
// Top level of the card number Luhn classifier: sequencing and output register.
//
// One item in, one item out. The slave channel s_* carries a 63-bit binary
// card number in s_tdata[62:0]; bit 63 is padding and is ignored. The master
// channel m_* carries the digit count, the Luhn result and the card kind.
//
// An item is first converted to 19 BCD digits, one binary bit per cycle,
// then the digits are scanned one per cycle to form the Luhn sum, the
// length and the two leading digits. When the output register is free,
// s_tready rises again in the same cycle as m_tvalid, so a new item is
// accepted only once the last one is through. The bit converter and the
// digit scanner are the two serial loops that set the time per item.
//
// The finished result sits in an output register, so the next item is taken
// while it waits. If the receiver stalls so long that a second result is
// ready before the first is taken, the second waits in the scanner and no
// further item is accepted until the output register frees.
//
// Reset clears all control state: s_tready comes up high, m_tvalid low.
module card_number_luhn_classifier
	import luhn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [62:0] card_number, [63] zero padding
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [4:0] digit_count, [5] checksum_ok, [7:6] card_kind
	output logic [M_TDATA_W-1:0] m_tdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic             m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic             s_accept;
	logic             conv_done;
	logic [BCD_W-1:0] bcd;
	logic             scan_done;
	luhn_res_t        res;
	logic             out_free;
	logic             load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign load     = (scan_done || state_q == ST_HOLD) && out_free;

	luhn_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_accept),
		.bin    (s_tdata[IN_W-1:0]),
		.done   (conv_done),
		.bcd    (bcd)
	);

	luhn_digit_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_done),
		.bcd    (bcd),
		.done   (scan_done),
		.res    (res)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			m_tvalid_q <= load || (m_tvalid_q && !m_tready);
			if (load) begin
				m_tdata_q  <= {res.card_kind, res.checksum_ok, res.digit_count};
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The converter only finishes while the sequencer waits for it.
	a_conv_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> state_q == ST_CONV)
		else $error("conversion finished outside the conversion phase");

	// The scanner only finishes while the sequencer waits for it.
	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == ST_SCAN)
		else $error("digit scan finished outside the scan phase");

	// Only one item is at work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready)
		else $error("second item accepted while one is at work");

	// A result is never loaded over one that has not been taken.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result overwritten before it was taken");

endmodule
